// ===== rtl/acpp_pkg.sv =====
// Shared types, character codes and helpers for the ASCII port command parser.
package acpp_pkg;

   // Number of ports that the command set can address.
   localparam int NUM_PORTS_DEF = 16;
   // Width of the reported port state.
   localparam int PORT_STATE_W = 16;
   // Stored bytes in a line before it counts as overlong.
   localparam int LINE_MAX = 8;
   // Characters of a well-formed command line, not counting the newline.
   localparam int CMD_CHARS = 6;
   // Depth of the queues between the parts of the block.
   localparam int QUEUE_DEPTH = 2;

   // Character codes.
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_FOUR  = 8'h34;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UE    = 8'h45;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_UI    = 8'h49;
   localparam logic [7:0] CH_UO    = 8'h4F;
   localparam logic [7:0] CH_UR    = 8'h52;
   localparam logic [7:0] CH_US    = 8'h53;
   localparam logic [7:0] CH_UT    = 8'h54;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF_HEX = 8'h66;
   // Offsets that turn letter codes into hex digit values.
   localparam logic [7:0] HEX_UPPER_OFS = 8'h37;
   localparam logic [7:0] HEX_LOWER_OFS = 8'h57;

   // Status codes of a result.
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_BADMSG  = 3'd1,
      ST_BADCMD  = 3'd2,
      ST_BADPORT = 3'd3,
      ST_BADSUM  = 3'd4
   } status_type;

   // A finished line handed from the front part to the back part.
   typedef struct packed {
      logic                     is_line;   // exactly six characters and a newline
      logic [CMD_CHARS-1:0][7:0] chars;    // characters in order, index 0 first
      logic [7:0]               head_sum;  // byte sum of the first four characters
   } line_item_type;

   // One result transaction.
   typedef struct packed {
      status_type              status;
      logic [PORT_STATE_W-1:0] port_state;
      logic                    blanked;
   } result_type;

   // Hex digit decode: bit 4 is the valid flag, bits 3:0 the value.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] diff;
      logic [4:0] res;
      diff = 8'h00;
      res  = 5'h00;
      if (c inside {[CH_ZERO:CH_NINE]}) begin
         diff = c - CH_ZERO;
         res  = {1'b1, diff[3:0]};
      end else if (c inside {[CH_UA:CH_UF]}) begin
         diff = c - HEX_UPPER_OFS;
         res  = {1'b1, diff[3:0]};
      end else if (c inside {[CH_LA:CH_LF_HEX]}) begin
         diff = c - HEX_LOWER_OFS;
         res  = {1'b1, diff[3:0]};
      end
      return res;
   endfunction

endpackage

// ===== rtl/acpp_fifo.sv =====
// Small synchronous queue used between the parts of the parser.
module acpp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   // Handshake qualification and status flags.
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage; needs no reset since empty entries are never shown.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The producer of this queue must respect full.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push while queue is full");

   // Occupancy never exceeds the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy out of range");

endmodule

// ===== rtl/acpp_front.sv =====
// Front part: assembles received bytes into lines and hands finished lines on.
module acpp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_valid,
   input  logic [7:0]             rx_byte,
   output logic                   item_push,
   output acpp_pkg::line_item_type item
);
   import acpp_pkg::*;

   logic [3:0]                len_ff, len_in;
   logic                      discard_ff, discard_in;
   logic [CMD_CHARS-1:0][7:0] chars_ff;
   logic [7:0]                sum_ff;
   logic                      store_byte;
   logic                      is_lf;

   assign is_lf      = (rx_byte == CH_LF);
   assign store_byte = byte_valid && !discard_ff && (rx_byte != CH_CR);

   // Line assembly: count stored bytes, end lines and enter discard mode.
   always_comb begin
      len_in     = len_ff;
      discard_in = discard_ff;
      item_push  = 1'b0;
      if (byte_valid && discard_ff) begin
         if (is_lf) begin
            discard_in = 1'b0;
         end
      end else if (store_byte) begin
         if (is_lf) begin
            len_in    = 4'd0;
            // A line that filled all stored places is dropped without a result.
            item_push = (len_ff < 4'(LINE_MAX - 1));
         end else if (len_ff == 4'(LINE_MAX - 1)) begin
            len_in     = 4'd0;
            discard_in = 1'b1;
         end else begin
            len_in = len_ff + 4'd1;
         end
      end
   end

   // The handed-on line uses the stored characters and running sum.
   always_comb begin
      item.is_line  = (len_ff == 4'(CMD_CHARS));
      item.chars    = chars_ff;
      item.head_sum = sum_ff;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= 4'd0;
         discard_ff <= 1'b0;
      end else begin
         len_ff     <= len_in;
         discard_ff <= discard_in;
      end
   end

   // Character storage and the checksum's running sum over the first four bytes.
   always_ff @(posedge clock) begin
      if (store_byte) begin
         if (len_ff < 4'(CMD_CHARS)) begin
            chars_ff[len_ff[2:0]] <= rx_byte;
         end
         if (len_ff == 4'd0) begin
            sum_ff <= rx_byte;
         end else if (len_ff < 4'd4) begin
            sum_ff <= sum_ff + rx_byte;
         end
      end
   end

   // Discard mode always starts from an empty line.
   a_discard_len: assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> (len_ff == 4'd0))
      else $error("line length nonzero in discard mode");

endmodule

// ===== rtl/acpp_back.sv =====
// Back part: checks each finished line and updates the port state.
module acpp_back #(
   parameter int NUM_PORTS = acpp_pkg::NUM_PORTS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  acpp_pkg::line_item_type item,
   output logic                    item_take,
   input  logic                    result_full,
   output logic                    result_push,
   output acpp_pkg::result_type    result
);
   import acpp_pkg::*;

   logic [NUM_PORTS-1:0] ports_ff, ports_in;
   status_type           status;
   logic                 blank;
   logic [4:0]           port_hi, port_lo, ck_hi, ck_lo;
   logic [7:0]           port_val, ck_val, total;
   logic                 port_ok;
   logic [NUM_PORTS-1:0] port_mask;

   assign item_take   = item_valid && !result_full;
   assign result_push = item_take;

   // Field decode of the line.
   always_comb begin
      port_hi   = hex_digit(item.chars[1]);
      port_lo   = hex_digit(item.chars[2]);
      ck_hi     = hex_digit(item.chars[4]);
      ck_lo     = hex_digit(item.chars[5]);
      port_val  = {port_hi[3:0], port_lo[3:0]};
      ck_val    = {ck_hi[3:0], ck_lo[3:0]};
      total     = item.head_sum + ck_val;
      port_ok   = port_hi[4] && port_lo[4] && (port_val < 8'(NUM_PORTS));
      port_mask = NUM_PORTS'(1) << port_val[3:0];
   end

   // Checks in their fixed order, then the port update.
   always_comb begin
      status   = ST_OK;
      blank    = 1'b0;
      ports_in = ports_ff;
      if (!item.is_line) begin
         status = ST_BADMSG;
      end else if (item.chars[0] == CH_UR) begin
         if (item.chars[1] != CH_US || item.chars[2] != CH_UT ||
             item.chars[3] != CH_HASH) begin
            status = ST_BADCMD;
         end else if (item.chars[4] != CH_UE || item.chars[5] != CH_FOUR) begin
            status = ST_BADSUM;
         end else begin
            ports_in = '0;
            blank    = 1'b1;
         end
      end else if (item.chars[0] != CH_UI && item.chars[0] != CH_UO) begin
         status = ST_BADCMD;
      end else if (!port_ok) begin
         status = ST_BADPORT;
      end else if (item.chars[3] != CH_HASH) begin
         status = ST_BADMSG;
      end else if (!ck_hi[4] || !ck_lo[4]) begin
         status = ST_BADMSG;
      end else if (total != 8'h00) begin
         status = ST_BADSUM;
      end else if (item.chars[0] == CH_UI) begin
         ports_in = ports_ff | port_mask;
      end else begin
         ports_in = ports_ff & ~port_mask;
      end
   end

   // Result transaction.
   always_comb begin
      result.status     = status;
      result.port_state = PORT_STATE_W'(ports_in);
      result.blanked    = blank;
   end

   // Port state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ports_ff <= '0;
      end else if (item_take) begin
         ports_ff <= ports_in;
      end
   end

   // A blanking result reports success and all ports off.
   a_blank_clears: assert property (@(posedge clock) disable iff (reset)
      (result_push && result.blanked) |->
         (result.status == ST_OK && result.port_state == '0))
      else $error("blanking result with ports on or bad status");

   // A rejected line leaves the ports alone.
   a_reject_keeps: assert property (@(posedge clock) disable iff (reset)
      (item_take && status != ST_OK) |=> (ports_ff == $past(ports_ff)))
      else $error("ports changed by a rejected line");

endmodule

// ===== rtl/ascii_port_command_parser.sv =====
// Top level of the ASCII port command parser.
// Bytes enter through a push/full queue interface, one transaction per cycle
// while full is low. Each line of six characters plus newline gives one status
// transaction on the empty/pop side: "IPP#CC" sets port PP, "OPP#CC" clears it,
// and "RST#E4" clears all ports with blanked set. Carriage returns are ignored,
// shorter lines report a bad message, lines that fill all eight stored places
// are dropped, and longer ones are discarded through the next newline. A
// finished line enters a two-entry queue at the edge that accepts its newline;
// once it heads that queue and the result queue has room, the checker that owns
// the port state takes it and pushes its result into the result queue. full
// rises only when both internal queues are backed up by an unread result queue.
module ascii_port_command_parser #(
   parameter int NUM_PORTS = acpp_pkg::NUM_PORTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rx_byte,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_port_state,
   output logic        rsp_blanked
);
   import acpp_pkg::*;

   localparam int ITEM_W   = $bits(line_item_type);
   localparam int RESULT_W = $bits(result_type);

   logic          byte_valid;
   logic          line_push, line_empty, line_take;
   line_item_type line_in, line_out;
   logic          res_push, res_full;
   result_type    res_in, res_out;

   assign byte_valid = push && !full;

   // Line assembly.
   acpp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .rx_byte    (req_rx_byte),
      .item_push  (line_push),
      .item       (line_in)
   );

   // Queue of finished lines.
   acpp_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_line_q (
      .clock     (clock),
      .reset     (reset),
      .push      (line_push),
      .push_data (line_in),
      .full      (full),
      .pop       (line_take),
      .empty     (line_empty),
      .pop_data  (line_out)
   );

   // Line checks and port state.
   acpp_back #(
      .NUM_PORTS (NUM_PORTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (!line_empty),
      .item        (line_out),
      .item_take   (line_take),
      .result_full (res_full),
      .result_push (res_push),
      .result      (res_in)
   );

   // Result queue facing the consumer.
   acpp_fifo #(
      .WIDTH (RESULT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_result_q (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_in),
      .full      (res_full),
      .pop       (pop),
      .empty     (empty),
      .pop_data  (res_out)
   );

   assign rsp_status     = res_out.status;
   assign rsp_port_state = res_out.port_state;
   assign rsp_blanked    = res_out.blanked;

endmodule

// ===== tb/ascii_port_command_parser_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the ASCII port command parser with its own line predictor.
module ascii_port_command_parser_test;
   import acpp_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 400;
   localparam int BYTE_TARGET   = 1200;

   typedef logic [7:0] char_q_type[$];

   logic        clock = 1'b0;
   logic        reset;
   logic        push;
   logic        full;
   logic [7:0]  req_rx_byte;
   logic        empty;
   logic        pop;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_port_state;
   logic        rsp_blanked;

   // Shadow copy of the parser state.
   logic [7:0]  line_chars [LINE_MAX];
   logic [3:0]  line_count;
   logic        in_discard;
   logic [15:0] port_bits;
   result_type  pending_results[$];

   // Traffic shaping and run statistics.
   bit tx_steady;
   bit rx_steady;
   int hold_request;
   int errors;
   int bytes_sent;
   int bytes_stored;
   int results_checked;
   int ok_lines;
   int blank_lines;
   int full_cycles;
   int longest_hold;

   // Clock generation.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ascii_port_command_parser #(
      .NUM_PORTS(NUM_PORTS_DEF)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_rx_byte(req_rx_byte),
      .empty(empty),
      .pop(pop),
      .rsp_status(rsp_status),
      .rsp_port_state(rsp_port_state),
      .rsp_blanked(rsp_blanked)
   );

   // Hex digit value of a character, or -1 when it is not a hex digit.
   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
      if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
      if (c >= CH_LA && c <= CH_LF_HEX) return int'(c - CH_LA) + 10;
      return -1;
   endfunction

   function automatic int hex_byte(input logic [7:0] hi, input logic [7:0] lo);
      int a;
      int b;
      a = hex_nibble(hi);
      b = hex_nibble(lo);
      if (a < 0 || b < 0) return -1;
      return a * 16 + b;
   endfunction

   // Checks a finished line in the fixed order and updates the port bits.
   function automatic status_type judge_line(input logic [3:0] n, output logic blank);
      int port;
      int cks;
      int total;
      blank = 1'b0;
      if (n != 4'd7) return ST_BADMSG;
      if (line_chars[0] == CH_UR) begin
         if (line_chars[1] != CH_US || line_chars[2] != CH_UT || line_chars[3] != CH_HASH)
            return ST_BADCMD;
         if (line_chars[4] != CH_UE || line_chars[5] != CH_FOUR) return ST_BADSUM;
         port_bits = '0;
         blank = 1'b1;
         return ST_OK;
      end
      if (line_chars[0] != CH_UI && line_chars[0] != CH_UO) return ST_BADCMD;
      port = hex_byte(line_chars[1], line_chars[2]);
      if (port < 0 || port >= NUM_PORTS_DEF) return ST_BADPORT;
      if (line_chars[3] != CH_HASH) return ST_BADMSG;
      cks = hex_byte(line_chars[4], line_chars[5]);
      if (cks < 0) return ST_BADMSG;
      total = cks + line_chars[0] + line_chars[1] + line_chars[2] + line_chars[3];
      if ((total & 'hFF) != 0) return ST_BADSUM;
      if (line_chars[0] == CH_UI) port_bits[port] = 1'b1;
      else port_bits[port] = 1'b0;
      return ST_OK;
   endfunction

   // Advances the shadow state by one accepted byte and queues any status it causes.
   task automatic predict_byte(input logic [7:0] b, output bit counted);
      result_type r;
      logic       blank;
      logic [3:0] n;
      counted = 1'b0;
      if (in_discard) begin
         if (b == CH_LF) in_discard = 1'b0;
         return;
      end
      if (b == CH_CR) return;
      counted = 1'b1;
      line_chars[line_count[2:0]] = b;
      line_count = line_count + 4'd1;
      if (b == CH_LF) begin
         n = line_count;
         line_count = '0;
         if (n >= LINE_MAX) return;
         r.status = judge_line(n, blank);
         r.port_state = port_bits;
         r.blanked = blank;
         if (r.status == ST_OK) ok_lines++;
         if (blank) blank_lines++;
         pending_results.push_back(r);
         return;
      end
      if (line_count >= LINE_MAX) begin
         line_count = '0;
         in_discard = 1'b1;
      end
   endtask

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
      return $urandom_range(1, 3);
   endfunction

   task automatic report_mismatch(input string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // Offers one byte, waits for the transaction to be taken and predicts its effect.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      bit counted;
      gap = 0;
      if (!tx_steady && $urandom_range(0, 4) == 0) gap = pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (full) begin
         full_cycles++;
         @(posedge clock);
      end
      predict_byte(b, counted);
      bytes_sent++;
      if (counted) bytes_stored++;
   endtask

   // Sends the characters and a newline, with carriage returns sprinkled in.
   task automatic send_line(input char_q_type chars, input int cr_pct);
      foreach (chars[i]) begin
         if ($urandom_range(0, 99) < cr_pct) send_byte(CH_CR);
         send_byte(chars[i]);
      end
      send_byte(CH_LF);
   endtask

   function automatic char_q_type from_text(input string s);
      char_q_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
      if (v < 4'd10) return CH_ZERO + v;
      return (lower ? CH_LA : CH_UA) + v - 8'd10;
   endfunction

   // Builds "<op><port>#<checksum>" with mixed-case hex and a right or wrong checksum.
   function automatic char_q_type make_cmd(input logic [7:0] op, input logic [7:0] port,
                                           input bit good_sum);
      char_q_type q;
      logic [7:0] c1;
      logic [7:0] c2;
      logic [7:0] cks;
      c1 = hex_char(port[7:4], 1'($urandom_range(0, 1)));
      c2 = hex_char(port[3:0], 1'($urandom_range(0, 1)));
      cks = 8'h00 - (op + c1 + c2 + CH_HASH);
      if (!good_sum) cks = cks + 8'($urandom_range(1, 255));
      q = '{op, c1, c2, CH_HASH};
      q.push_back(hex_char(cks[7:4], 1'($urandom_range(0, 1))));
      q.push_back(hex_char(cks[3:0], 1'($urandom_range(0, 1))));
      return q;
   endfunction

   // Random characters; without line breaks when asked.
   function automatic char_q_type random_chars(input int n, input bit no_breaks);
      char_q_type q;
      logic [7:0] c;
      for (int i = 0; i < n; i++) begin
         c = 8'($urandom_range(0, 255));
         if (no_breaks && (c == CH_LF || c == CH_CR)) c = CH_UA;
         q.push_back(c);
      end
      return q;
   endfunction

   // Stops offering bytes until every expected status has been received.
   task automatic wait_idle();
      push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Compares one received status transaction with the oldest expectation.
   task automatic check_result();
      result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch($sformatf("unexpected result status=%0d ports=%h blanked=%0b",
                                   rsp_status, rsp_port_state, rsp_blanked));
         return;
      end
      want = pending_results.pop_front();
      results_checked++;
      if (rsp_status !== want.status)
         report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
      if (rsp_port_state !== want.port_state)
         report_mismatch($sformatf("port_state %h, expected %h", rsp_port_state,
                                   want.port_state));
      if (rsp_blanked !== want.blanked)
         report_mismatch($sformatf("blanked %0b, expected %0b", rsp_blanked, want.blanked));
   endtask

   // Result side: takes transactions, stalls at random and honors a long hold request.
   initial begin
      int stall_left;
      stall_left = 0;
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) check_result();
         if (hold_request > 0) begin
            stall_left = hold_request;
            if (hold_request > longest_hold) longest_hold = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else if (!rx_steady && $urandom_range(0, 4) == 0) begin
            stall_left = pick_gap() - 1;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Every command and every check outcome, in a fixed order.
   task automatic test_command_checks();
      send_line(from_text("I00#34"), 0);   // set port 0
      send_line(from_text("I0F#1e"), 0);   // set port 15, lowercase checksum
      send_line(from_text("I0a#03"), 0);   // set port 10, lowercase port digit
      send_line(from_text("O00#2E"), 0);   // clear port 0
      send_line(from_text("O00#2F"), 0);   // bad checksum
      send_line(from_text("I10#33"), 0);   // port 16 is out of range
      send_line(from_text("I0G#34"), 0);   // invalid port digit
      send_line(from_text("IG0#00"), 0);
      send_line(from_text("I05?00"), 0);   // wrong separator
      send_line(from_text("I05#Z0"), 0);   // invalid checksum digit
      send_line(from_text("X00#00"), 0);   // unknown command
      send_line(from_text("RSX#E4"), 0);   // R line that is not a reset
      send_line(from_text("RST#E5"), 0);   // reset with a wrong checksum
      send_line(from_text("RST#e4"), 0);
      send_line(from_text("RST#E4"), 0);   // blanking reset
   endtask

   // Line lengths, carriage returns, full lines and discard mode.
   task automatic test_line_framing();
      send_byte(CH_LF);                    // empty line
      send_byte(CH_CR);                    // a lone carriage return is invisible
      send_byte(CH_LF);
      send_line(from_text("ABC"), 0);
      send_byte(8'hFF);                    // extreme byte values in a short line
      send_byte(8'h00);
      send_byte(CH_LF);
      send_line(from_text("I00#340"), 0);  // eight stored bytes: dropped quietly
      send_line(from_text("I00#34"), 0);
      // Overlong line: everything up to the next newline is dropped.
      send_line(from_text("I00#3400RST#E4"), 30);
      send_line(from_text("I01#33"), 50);
      send_byte(CH_CR);
      send_line(from_text("RST#E4"), 0);
   endtask

   // Mostly well-formed commands with random content, plus broken lines and noise.
   task automatic test_random_traffic(input int count);
      int         stop_at;
      int         kind;
      int         iter;
      char_q_type q;
      stop_at = bytes_stored + count;
      iter = 0;
      while (bytes_stored < stop_at) begin
         if (iter % 40 == 0) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
         end
         iter++;
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            q = make_cmd($urandom_range(0, 1) ? CH_UI : CH_UO,
                         8'(($urandom_range(0, 19) == 0) ? $urandom_range(16, 255)
                                                         : $urandom_range(0, 15)),
                         $urandom_range(0, 9) != 0);
            send_line(q, 5);
         end else if (kind < 63) begin
            q = from_text("RST#E4");
            if ($urandom_range(0, 1)) q[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
            send_line(q, 5);
         end else if (kind < 75) begin
            q = make_cmd($urandom_range(0, 1) ? CH_UI : CH_UO, 8'($urandom_range(0, 15)),
                         1'b1);
            q[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
            send_line(q, 5);
         end else if (kind < 83) begin
            send_line(random_chars($urandom_range(0, 5), 1'b1), 10);
         end else if (kind < 88) begin
            send_line(random_chars(7, 1'b1), 10);
         end else if (kind < 93) begin
            send_line(random_chars($urandom_range(8, 14), 1'b1), 10);
         end else begin
            q = random_chars($urandom_range(1, 6), 1'b0);
            foreach (q[i]) send_byte(q[i]);
         end
      end
      tx_steady = 1'b0;
      rx_steady = 1'b0;
   endtask

   // The result side holds off while the sender keeps going, so full has to rise.
   task automatic test_full_backpressure();
      tx_steady = 1'b1;
      hold_request = HOLD_CYCLES;
      repeat (30)
         send_line(make_cmd($urandom_range(0, 1) ? CH_UI : CH_UO, 8'($urandom_range(0, 15)),
                            1'b1), 0);
      tx_steady = 1'b0;
   endtask

   // The sender pauses until every status is in, then traffic resumes.
   task automatic test_drain_pause();
      test_random_traffic(60);
      wait_idle();
      test_random_traffic(60);
   endtask

   // Timeout guard.
   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Test sequence.
   initial begin
      reset <= 1'b1;
      push <= 1'b0;
      req_rx_byte <= 8'h00;
      line_count = '0;
      in_discard = 1'b0;
      port_bits = '0;
      tx_steady = 1'b0;
      rx_steady = 1'b0;
      hold_request = 0;
      errors = 0;
      bytes_sent = 0;
      bytes_stored = 0;
      results_checked = 0;
      ok_lines = 0;
      blank_lines = 0;
      full_cycles = 0;
      longest_hold = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_command_checks();
      test_line_framing();
      test_random_traffic(BYTE_TARGET / 4);
      test_full_backpressure();
      test_drain_pause();
      test_random_traffic(BYTE_TARGET / 4);

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d bytes, checked %0d status transactions (%0d accepted, %0d blanking).",
               bytes_sent, results_checked, ok_lines, blank_lines);
      $display("Input stalled by full for %0d cycles; longest result hold-off %0d cycles.",
               full_cycles, longest_hold);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/acpp_pkg.sv
rtl/acpp_fifo.sv
rtl/acpp_front.sv
rtl/acpp_back.sv
rtl/ascii_port_command_parser.sv
tb/ascii_port_command_parser_test.sv
